@@ hw/rtl/cda_pkg.sv @@
package cda_pkg;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // Divide by 100 for years below 43699: (y * 5243) >> 19
  localparam logic [26:0] DIV100_MUL = 27'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_DAYS   = 2'd1,
    ACT_MONTHS = 2'd2,
    ACT_YEARS  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADSET = 2'd1,
    ST_OVF    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP_Q,
    S_LEAP_F,
    S_SET,
    S_WALK,
    S_MDIV,
    S_YCHK,
    S_CLAMP,
    S_FIN
  } ctl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LEAP_Q,
    CMD_LEAP_F,
    CMD_SET,
    CMD_WALK,
    CMD_MDIV,
    CMD_YCHK,
    CMD_CLAMP,
    CMD_FIN
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    mdiv_done;
    logic    walk_end;
    logic    walk_year;
    logic    ny_ovf;
    logic    out_free;
  } dp_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/calendar_date_adder.sv @@
// Gregorian date register with add-days, add-months and add-years commands.
// Each input word sets the date or adds to it and yields exactly one result word
// carrying the new date and a status (ok, invalid set ignored, year overflow
// saturated to 9999-12-31). Reset date is 0000-01-01; year 0 is a leap year.
// One word is worked at a time. A set runs the leap test before it checks the
// fields; add-months first takes twelve months at a time off the total, and both
// add-months and add-years then redo the leap test and clamp the day. Adding
// days walks the calendar one month per cycle, pausing at each year boundary
// to redo the leap test. A finished result sits in an output register, so the
// next word is taken while it waits.
module calendar_date_adder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [13:0] year_in, [21:14] month_in, [33:22] day_in, rest 0
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [13:0] year_out, [17:14] month_out, [22:18] day_out, [23] 0
  output logic [1:0]  out_tuser   // [1:0] status
);

  cda_pkg::dp_cmd_t  cmd;
  cda_pkg::dp_stat_t stat;
  cda_pkg::action_t  in_action;
  cda_pkg::status_t  out_status;
  logic [13:0]       out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day;

  assign in_action = cda_pkg::action_t'(in_tuser);

  // Sequence the work of one word
  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_action),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the date, the leap test and the output register
  cda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (in_action),
    .in_year    (in_tdata[13:0]),
    .in_month   (in_tdata[21:14]),
    .in_day     (in_tdata[33:22]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_year   (out_year),
    .out_month  (out_month),
    .out_day    (out_day),
    .out_status (out_status)
  );

  assign out_tdata = {1'b0, out_day, out_month, out_year};
  assign out_tuser = out_status;

endmodule

@@ hw/rtl/cda_ctrl.sv @@
module cda_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  cda_pkg::action_t   in_action,
  output logic               in_tready,
  input  cda_pkg::dp_stat_t  stat,
  output cda_pkg::dp_cmd_t   cmd
);

  cda_pkg::ctl_state_t state_r;
  cda_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cda_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_action)
            cda_pkg::ACT_SET,
            cda_pkg::ACT_DAYS:   state_nxt = cda_pkg::S_LEAP_Q;
            cda_pkg::ACT_MONTHS: state_nxt = cda_pkg::S_MDIV;
            default:             state_nxt = cda_pkg::S_YCHK;
          endcase
        end
      end
      cda_pkg::S_LEAP_Q: state_nxt = cda_pkg::S_LEAP_F;
      cda_pkg::S_LEAP_F: begin
        unique case (stat.act)
          cda_pkg::ACT_SET:  state_nxt = cda_pkg::S_SET;
          cda_pkg::ACT_DAYS: state_nxt = cda_pkg::S_WALK;
          default:           state_nxt = cda_pkg::S_CLAMP;
        endcase
      end
      cda_pkg::S_SET: state_nxt = cda_pkg::S_FIN;
      cda_pkg::S_WALK: begin
        priority if (stat.walk_end) begin
          state_nxt = cda_pkg::S_FIN;
        end else if (stat.walk_year) begin
          state_nxt = cda_pkg::S_LEAP_Q;
        end
      end
      cda_pkg::S_MDIV: begin
        if (stat.mdiv_done) begin
          state_nxt = cda_pkg::S_YCHK;
        end
      end
      cda_pkg::S_YCHK: state_nxt = stat.ny_ovf ? cda_pkg::S_FIN : cda_pkg::S_LEAP_Q;
      cda_pkg::S_CLAMP: state_nxt = cda_pkg::S_FIN;
      cda_pkg::S_FIN: begin
        if (stat.out_free) begin
          state_nxt = cda_pkg::S_IDLE;
        end
      end
      default: state_nxt = cda_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = cda_pkg::CMD_NONE;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd       = in_tvalid ? cda_pkg::CMD_LOAD : cda_pkg::CMD_NONE;
      end
      cda_pkg::S_LEAP_Q: cmd = cda_pkg::CMD_LEAP_Q;
      cda_pkg::S_LEAP_F: cmd = cda_pkg::CMD_LEAP_F;
      cda_pkg::S_SET:    cmd = cda_pkg::CMD_SET;
      cda_pkg::S_WALK:   cmd = cda_pkg::CMD_WALK;
      cda_pkg::S_MDIV:   cmd = cda_pkg::CMD_MDIV;
      cda_pkg::S_YCHK:   cmd = cda_pkg::CMD_YCHK;
      cda_pkg::S_CLAMP:  cmd = cda_pkg::CMD_CLAMP;
      cda_pkg::S_FIN:    cmd = cda_pkg::CMD_FIN;
      default:           cmd = cda_pkg::CMD_NONE;
    endcase
  end

endmodule

@@ hw/rtl/cda_dp.sv @@
module cda_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cda_pkg::dp_cmd_t   cmd,
  output cda_pkg::dp_stat_t  stat,
  input  cda_pkg::action_t   in_action,
  input  logic [13:0]        in_year,
  input  logic [7:0]         in_month,
  input  logic [11:0]        in_day,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output cda_pkg::status_t   out_status
);

  // Architectural date
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;

  // Item under work
  cda_pkg::action_t act_r;
  cda_pkg::status_t st_r;
  logic [13:0] yin_r;
  logic [7:0]  min_r;
  logic [11:0] din_r;
  logic [12:0] t_r;
  logic [8:0]  total_r;
  logic [14:0] ny_r;
  logic [7:0]  q_r;
  logic        leap_r;

  // Output register
  logic             out_valid_r;
  logic [13:0]      out_year_r;
  logic [3:0]       out_month_r;
  logic [4:0]       out_day_r;
  cda_pkg::status_t out_st_r;

  logic [13:0] probe;
  logic [26:0] prod;
  logic [13:0] rem;
  logic        leap_nxt;
  logic [4:0]  cur_len;
  logic [4:0]  set_len;
  logic        set_ok;
  logic        walk_over;
  logic        at_dec;
  logic        year_top;
  logic        out_free;

  // Leap test: y/100 by reciprocal, then the remainder from it
  assign probe    = (act_r == cda_pkg::ACT_SET) ? yin_r : year_r;
  assign prod     = {13'd0, probe} * cda_pkg::DIV100_MUL;
  assign rem      = probe - 14'({6'd0, q_r} * 14'd100);
  assign leap_nxt = (probe[1:0] == 2'b00) && ((rem != 14'd0) || (q_r[1:0] == 2'b00));

  assign cur_len = cda_pkg::month_len(month_r, leap_r);
  assign set_len = cda_pkg::month_len(min_r[3:0], leap_r);
  assign set_ok  = (yin_r <= cda_pkg::YEAR_MAX) && (min_r >= 8'd1) && (min_r <= 8'd12) &&
                   (din_r >= 12'd1) && (din_r <= {7'd0, set_len});

  assign walk_over = t_r > {8'd0, cur_len};
  assign at_dec    = month_r == 4'd12;
  assign year_top  = year_r >= cda_pkg::YEAR_MAX;
  assign out_free  = !out_valid_r || out_ready;

  assign stat.act       = act_r;
  assign stat.mdiv_done = total_r < 9'd12;
  assign stat.walk_end  = !walk_over || (at_dec && year_top);
  assign stat.walk_year = walk_over && at_dec && !year_top;
  assign stat.ny_ovf    = ny_r > {1'b0, cda_pkg::YEAR_MAX};
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= 14'd0;
      month_r     <= 4'd1;
      day_r       <= 5'd1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd)
        cda_pkg::CMD_LOAD: begin
          act_r   <= in_action;
          st_r    <= cda_pkg::ST_OK;
          yin_r   <= in_year;
          min_r   <= in_month;
          din_r   <= in_day;
          t_r     <= {8'd0, day_r} + {1'b0, in_day};
          total_r <= {5'd0, month_r} - 9'd1 + {1'b0, in_month};
          ny_r    <= (in_action == cda_pkg::ACT_YEARS) ?
                     ({1'b0, year_r} + {1'b0, in_year}) : {1'b0, year_r};
        end
        cda_pkg::CMD_LEAP_Q: q_r    <= prod[26:cda_pkg::DIV100_SHIFT];
        cda_pkg::CMD_LEAP_F: leap_r <= leap_nxt;
        cda_pkg::CMD_SET: begin
          if (set_ok) begin
            year_r  <= yin_r;
            month_r <= min_r[3:0];
            day_r   <= din_r[4:0];
          end else begin
            st_r <= cda_pkg::ST_BADSET;
          end
        end
        cda_pkg::CMD_WALK: begin
          // Advance one month a cycle; a year crossing goes back for a new leap flag
          if (walk_over) begin
            if (at_dec) begin
              if (year_top) begin
                year_r  <= cda_pkg::YEAR_MAX;
                month_r <= 4'd12;
                day_r   <= 5'd31;
                st_r    <= cda_pkg::ST_OVF;
              end else begin
                year_r  <= year_r + 14'd1;
                month_r <= 4'd1;
                t_r     <= t_r - {8'd0, cur_len};
              end
            end else begin
              month_r <= month_r + 4'd1;
              t_r     <= t_r - {8'd0, cur_len};
            end
          end else begin
            day_r <= t_r[4:0];
          end
        end
        cda_pkg::CMD_MDIV: begin
          if (!stat.mdiv_done) begin
            total_r <= total_r - 9'd12;
            ny_r    <= ny_r + 15'd1;
          end
        end
        cda_pkg::CMD_YCHK: begin
          if (stat.ny_ovf) begin
            year_r  <= cda_pkg::YEAR_MAX;
            month_r <= 4'd12;
            day_r   <= 5'd31;
            st_r    <= cda_pkg::ST_OVF;
          end else begin
            year_r <= ny_r[13:0];
            if (act_r == cda_pkg::ACT_MONTHS) begin
              month_r <= total_r[3:0] + 4'd1;
            end
          end
        end
        cda_pkg::CMD_CLAMP: begin
          if (day_r > cur_len) begin
            day_r <= cur_len;
          end
        end
        default: begin
        end
      endcase

      if ((cmd == cda_pkg::CMD_FIN) && out_free) begin
        out_valid_r <= 1'b1;
        out_year_r  <= year_r;
        out_month_r <= month_r;
        out_day_r   <= day_r;
        out_st_r    <= st_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_year   = out_year_r;
  assign out_month  = out_month_r;
  assign out_day    = out_day_r;
  assign out_status = out_st_r;

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (month_r >= 4'd1) && (month_r <= 4'd12))
    else $error("month left 1..12");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (day_r >= 5'd1) && (day_r <= 5'd31))
    else $error("day left 1..31");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    year_r <= cda_pkg::YEAR_MAX)
    else $error("year beyond limit");

  a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == cda_pkg::ST_OVF)) |->
    ((out_year_r == cda_pkg::YEAR_MAX) && (out_month_r == 4'd12) && (out_day_r == 5'd31)))
    else $error("overflow result not saturated");

endmodule

@@ verif/date_check_pkg.sv @@
package date_check_pkg;

  typedef struct {
    logic [13:0]      year;
    logic [3:0]       month;
    logic [4:0]       day;
    cda_pkg::status_t status;
  } date_result_t;

  // Mirrors the date register and queues the result word each accepted input word must produce.
  class date_scoreboard;
    int unsigned  cur_y;
    int unsigned  cur_m;
    int unsigned  cur_d;
    date_result_t expected_q[$];
    int           failures;
    int           checked;
    int           act_count[4];
    int           badset_count;
    int           ovf_count;

    function new();
      cur_y = 0;
      cur_m = 1;
      cur_d = 1;
      failures = 0;
      checked = 0;
      badset_count = 0;
      ovf_count = 0;
      foreach (act_count[i]) act_count[i] = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    static function int unsigned days_in(int unsigned y, int unsigned m);
      case (m)
        2:           return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function void saturate();
      cur_y = 32'(cda_pkg::YEAR_MAX);
      cur_m = 12;
      cur_d = 31;
    endfunction

    function void clamp_day();
      if (cur_d > days_in(cur_y, cur_m)) cur_d = days_in(cur_y, cur_m);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(cda_pkg::action_t act, logic [13:0] yin, logic [7:0] mon,
                             logic [11:0] dd);
      int unsigned      t;
      int unsigned      len;
      int unsigned      total;
      int unsigned      ny;
      cda_pkg::status_t st;
      date_result_t     res;
      st = cda_pkg::ST_OK;
      act_count[act]++;
      case (act)
        cda_pkg::ACT_SET: begin
          if (yin > cda_pkg::YEAR_MAX || mon < 8'd1 || mon > 8'd12 || dd < 12'd1 ||
              32'(dd) > days_in(32'(yin), 32'(mon))) begin
            st = cda_pkg::ST_BADSET;
          end else begin
            cur_y = 32'(yin);
            cur_m = 32'(mon);
            cur_d = 32'(dd);
          end
        end
        cda_pkg::ACT_DAYS: begin
          // walk one month at a time, carry into the year at December
          t = cur_d + 32'(dd);
          len = days_in(cur_y, cur_m);
          while (t > len && st == cda_pkg::ST_OK) begin
            t -= len;
            if (cur_m == 12) begin
              if (cur_y >= 32'(cda_pkg::YEAR_MAX)) begin
                st = cda_pkg::ST_OVF;
              end else begin
                cur_y++;
                cur_m = 1;
              end
            end else begin
              cur_m++;
            end
            len = days_in(cur_y, cur_m);
          end
          if (st == cda_pkg::ST_OVF) saturate();
          else cur_d = t;
        end
        cda_pkg::ACT_MONTHS: begin
          total = (cur_m - 1) + 32'(mon);
          ny = cur_y + total / 12;
          if (ny > 32'(cda_pkg::YEAR_MAX)) begin
            st = cda_pkg::ST_OVF;
            saturate();
          end else begin
            cur_y = ny;
            cur_m = total % 12 + 1;
            clamp_day();
          end
        end
        default: begin
          ny = cur_y + 32'(yin);
          if (ny > 32'(cda_pkg::YEAR_MAX)) begin
            st = cda_pkg::ST_OVF;
            saturate();
          end else begin
            cur_y = ny;
            clamp_day();
          end
        end
      endcase
      if (st == cda_pkg::ST_BADSET) badset_count++;
      if (st == cda_pkg::ST_OVF) ovf_count++;
      res.year = 14'(cur_y);
      res.month = 4'(cur_m);
      res.day = 5'(cur_d);
      res.status = st;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [23:0] word, logic [1:0] flags);
      date_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word %h status %0d arrived with nothing expected", word, flags);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (word[13:0] !== want.year) begin
        $error("year_out: expected %0d, got %0d", want.year, word[13:0]);
        failures++;
      end
      if (word[17:14] !== want.month) begin
        $error("month_out: expected %0d, got %0d", want.month, word[17:14]);
        failures++;
      end
      if (word[22:18] !== want.day) begin
        $error("day_out: expected %0d, got %0d", want.day, word[22:18]);
        failures++;
      end
      if (flags !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, flags);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ verif/calendar_date_adder_test.sv @@
module calendar_date_adder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycle limit for the whole run; the watchdog gives up when it is reached.
  localparam int LIMIT_CYCLES = 600000;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 400;
  // Settle time after the last result, beyond the longest single word.
  localparam int TAIL_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [13:0] year_in, [21:14] month_in, [33:22] day_in, rest 0
  logic [1:0]  in_tuser;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [13:0] year_out, [17:14] month_out, [22:18] day_out, [23] 0
  logic [1:0]  out_tuser;  // [1:0] status

  date_check_pkg::date_scoreboard sb;
  int             send_idle_pct = 26;
  int             recv_idle_pct = 65;
  bit             hold_req = 1'b0;
  int             hold_left = 0;
  int             cycle_count = 0;

  calendar_date_adder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: give up if the run drags past the cycle limit.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  // Offer one word; idle first at the current rate, then hold it until the block takes it.
  // Leave tvalid high on return so back-to-back words never drop it within one step.
  task automatic send_word(cda_pkg::action_t act, logic [13:0] yin, logic [7:0] mon,
                           logic [11:0] dd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'b0, dd, mon, yin};
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, yin, mon, dd);
  endtask

  // Mostly well-formed sets and moderate additions so the date wanders across the whole
  // calendar; a slice of full-width noise keeps every field bit toggling and hits rejects
  // and saturation. Fields the action ignores always carry random junk.
  task automatic send_random();
    int          r;
    logic [13:0] y;
    logic [7:0]  m;
    logic [11:0] d;
    r = $urandom_range(99);
    y = 14'($urandom_range(16383));
    m = 8'($urandom_range(255));
    d = 12'($urandom_range(4095));
    if (r < 25) begin
      y = ($urandom_range(99) < 15) ? 14'($urandom_range(9950, 9999)) :
                                      14'($urandom_range(9999));
      m = 8'($urandom_range(1, 12));
      d = 12'($urandom_range(1, date_check_pkg::date_scoreboard::days_in(32'(y), 32'(m))));
      send_word(cda_pkg::ACT_SET, y, m, d);
    end else if (r < 32) begin
      // raw set: often rejected
      send_word(cda_pkg::ACT_SET, y, m, d);
    end else if (r < 60) begin
      if ($urandom_range(99) < 80) d = 12'($urandom_range(400));
      send_word(cda_pkg::ACT_DAYS, y, m, d);
    end else if (r < 80) begin
      if ($urandom_range(99) < 60) m = 8'($urandom_range(30));
      send_word(cda_pkg::ACT_MONTHS, y, m, d);
    end else begin
      if ($urandom_range(99) < 85) y = 14'($urandom_range(30));
      send_word(cda_pkg::ACT_YEARS, y, m, d);
    end
  endtask

  // Drop tvalid and hold off until every expected result is back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check every accepted word, then pick tready for the next edge.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= cda_pkg::ACT_SET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero additions, leap rules, rejected sets, clamping, extremes, saturation.
    send_word(cda_pkg::ACT_DAYS,   14'h3FFF, 8'hFF, 12'd0);     // nothing added to reset date
    send_word(cda_pkg::ACT_SET,    14'd0,    8'd2,  12'd29);    // year 0 is leap
    send_word(cda_pkg::ACT_YEARS,  14'd1,    8'd0,  12'd0);     // Feb 29 clamps to Feb 28
    send_word(cda_pkg::ACT_SET,    14'd1900, 8'd2,  12'd29);    // century, not leap: reject
    send_word(cda_pkg::ACT_SET,    14'd2000, 8'd2,  12'd29);    // divisible by 400: leap
    send_word(cda_pkg::ACT_SET,    14'd10000, 8'd1, 12'd1);     // year just past the top
    send_word(cda_pkg::ACT_SET,    14'h3FFF, 8'd12, 12'd31);    // all year bits set
    send_word(cda_pkg::ACT_SET,    14'd2024, 8'd0,  12'd1);     // month zero
    send_word(cda_pkg::ACT_SET,    14'd2024, 8'd13, 12'd1);     // month past December
    send_word(cda_pkg::ACT_SET,    14'd2024, 8'hFF, 12'hFFF);   // both fields at maximum
    send_word(cda_pkg::ACT_SET,    14'd2024, 8'd4,  12'd31);    // April 31
    send_word(cda_pkg::ACT_SET,    14'd2024, 8'd1,  12'd0);     // day zero
    send_word(cda_pkg::ACT_SET,    14'd2024, 8'd1,  12'd31);
    send_word(cda_pkg::ACT_MONTHS, 14'd0,    8'd1,  12'd0);     // Jan 31 plus a month: Feb 29
    send_word(cda_pkg::ACT_MONTHS, 14'h3FFF, 8'd0,  12'hFFF);   // zero months
    send_word(cda_pkg::ACT_YEARS,  14'd0,    8'hFF, 12'hFFF);   // zero years
    send_word(cda_pkg::ACT_DAYS,   14'd0,    8'd0,  12'hFFF);   // longest walk
    send_word(cda_pkg::ACT_MONTHS, 14'd0,    8'hFF, 12'd0);     // most months at once
    send_word(cda_pkg::ACT_SET,    14'd9999, 8'd12, 12'd31);    // last representable date
    send_word(cda_pkg::ACT_DAYS,   14'd0,    8'd0,  12'd1);     // overflow by days
    send_word(cda_pkg::ACT_MONTHS, 14'd0,    8'd1,  12'd0);     // overflow by months
    send_word(cda_pkg::ACT_YEARS,  14'h3FFF, 8'd0,  12'd0);     // overflow by years
    send_word(cda_pkg::ACT_SET,    14'd9998, 8'd12, 12'd31);
    send_word(cda_pkg::ACT_DAYS,   14'd0,    8'd0,  12'd365);   // lands on 9999-12-31
    send_word(cda_pkg::ACT_SET,    14'd2100, 8'd2,  12'd29);    // another non-leap century

    // Phase one: sender idles lightly, receiver heavily.
    repeat (75) send_random();
    // Pause the sender until everything is back.
    wait_drained();

    // Phase two: swap the idle rates.
    send_idle_pct = 65;
    recv_idle_pct = 26;
    repeat (85) send_random();
    wait_drained();

    // Phase three: no idling, but start with a long receiver hold-off so the block
    // backs up and stalls its input while words keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (85) send_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d words (set %0d, days %0d, months %0d, years %0d), %0d results checked",
             sb.act_count[cda_pkg::ACT_SET] + sb.act_count[cda_pkg::ACT_DAYS] +
             sb.act_count[cda_pkg::ACT_MONTHS] + sb.act_count[cda_pkg::ACT_YEARS],
             sb.act_count[cda_pkg::ACT_SET], sb.act_count[cda_pkg::ACT_DAYS],
             sb.act_count[cda_pkg::ACT_MONTHS], sb.act_count[cda_pkg::ACT_YEARS], sb.checked);
    $display("run: %0d rejected sets, %0d year saturations, %0d mismatches",
             sb.badset_count, sb.ovf_count, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
